FILE: design/ies_pkg.sv
// Shared types and constants for the serial EEPROM transaction sequencer.
// Used by ies_ctrl, ies_dp and the top level; depends on nothing else.
`default_nettype none
package ies_pkg;

  // Register defaults and widths
  localparam int          ADDR_BITS_DEF = 16;
  localparam logic [6:0]  DEV_RST       = 7'h50;
  localparam logic [8:0]  PAGE_RST      = 9'd16;
  localparam logic [8:0]  PAGE_MAX      = 9'd256;
  localparam logic [7:0]  RETRY_RST     = 8'd32;
  localparam logic [7:0]  WAIT_RST      = 8'd5;
  localparam int          CFG_IDX_W     = 3;
  localparam int          CFG_DATA_W    = 9;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEV   = 3'd0,
    REG_PAGE  = 3'd1,
    REG_WIDE  = 3'd2,
    REG_RETRY = 3'd3,
    REG_WAIT  = 3'd4
  } reg_idx_t;

  // Host and response commands
  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_READY = 2'd2,
    CMD_RESP  = 2'd3
  } cmd_t;

  // Bus primitives
  typedef enum logic [2:0] {
    OP_START   = 3'd0,
    OP_RESTART = 3'd1,
    OP_WRITE   = 3'd2,
    OP_READ    = 3'd3,
    OP_STOP    = 3'd4,
    OP_PROBE   = 3'd5,
    OP_WAIT    = 3'd6,
    OP_NONE    = 3'd7
  } bus_op_t;

  // Transaction phase: which primitive answer is awaited
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_CTRL  = 3'd1,
    PH_AHI   = 3'd2,
    PH_ALO   = 3'd3,
    PH_DATA  = 3'd4,
    PH_PROBE = 3'd5,
    PH_RCTRL = 3'd6,
    PH_READ  = 3'd7
  } phase_t;

  // Kind of the host request in flight
  typedef enum logic [1:0] {
    RK_BYTE     = 2'd0,
    RK_LASTBYTE = 2'd1,
    RK_READ     = 2'd2,
    RK_READY    = 2'd3
  } req_kind_t;

  // Controller states
  typedef enum logic [2:0] {
    CS_IDLE   = 3'd0,
    CS_EVAL   = 3'd1,
    CS_MOD    = 3'd2,
    CS_COMMIT = 3'd3,
    CS_EMIT   = 3'd4
  } ctl_state_t;

  // One result word, without the last marker
  typedef struct packed {
    bus_op_t    op;
    logic [7:0] bus_byte;
    logic       done;
    logic       ok;
    logic [7:0] rdata;
  } result_t;

  // Controller to datapath commands
  typedef struct packed {
    logic latch_in;
    logic mod_start;
    logic commit;
    logic emit_load;
    logic emit_idx;
    logic emit_last;
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic       need_mod;
    logic       mod_busy;
    logic [1:0] res_count;
    logic       out_free;
  } dp_status_t;

endpackage
`default_nettype wire

FILE: design/ies_ctrl.sv
// Sequencing state machine: accepts an item, starts the page offset unit,
// commits the step and hands result words to the output register. Uses ies_pkg.
`default_nettype none
module ies_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  ies_pkg::dp_status_t  status,
  output ies_pkg::ctl_cmd_t    cmd
);

  ies_pkg::ctl_state_t state_r, state_nxt;
  logic                idx_r, idx_nxt;
  logic                is_last;

  // The current result word is the last one of the step.
  assign is_last = ({1'b0, idx_r} == (status.res_count - 2'd1));

  // State and word index registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ies_pkg::CS_IDLE;
      idx_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Next state. The word count of the step is valid once the commit has landed.
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    case (state_r)
      ies_pkg::CS_IDLE: begin
        if (in_valid) state_nxt = ies_pkg::CS_EVAL;
      end
      ies_pkg::CS_EVAL: begin
        state_nxt = status.need_mod ? ies_pkg::CS_MOD : ies_pkg::CS_COMMIT;
      end
      ies_pkg::CS_MOD: begin
        if (!status.mod_busy) state_nxt = ies_pkg::CS_COMMIT;
      end
      ies_pkg::CS_COMMIT: begin
        idx_nxt   = 1'b0;
        state_nxt = ies_pkg::CS_EMIT;
      end
      ies_pkg::CS_EMIT: begin
        if (status.res_count == 2'd0) begin
          state_nxt = ies_pkg::CS_IDLE;
        end else if (status.out_free) begin
          if (is_last) state_nxt = ies_pkg::CS_IDLE;
          else idx_nxt = 1'b1;
        end
      end
      default: state_nxt = ies_pkg::CS_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ies_pkg::CS_IDLE: begin
        in_stall     = 1'b0;
        cmd.latch_in = in_valid;
      end
      ies_pkg::CS_EVAL: begin
        cmd.mod_start = status.need_mod;
      end
      ies_pkg::CS_MOD: begin
        cmd.commit = !status.mod_busy ? 1'b0 : 1'b0;
      end
      ies_pkg::CS_COMMIT: begin
        cmd.commit = 1'b1;
      end
      ies_pkg::CS_EMIT: begin
        cmd.emit_load = status.out_free && (status.res_count != 2'd0);
        cmd.emit_idx  = idx_r;
        cmd.emit_last = is_last;
      end
      default: cmd = '0;
    endcase
  end

`ifndef SYNTHESIS
  // Only the idle state takes input.
  a_stall_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_stall) |-> (state_r == ies_pkg::CS_IDLE))
    else $error("input taken outside idle");
  // The second word is only ever loaded for a step of two words.
  a_idx_order: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_load && cmd.emit_idx) |-> (status.res_count == 2'd2))
    else $error("second word loaded for a one word step");
  // A step without results returns straight to idle.
  a_zero_res: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ies_pkg::CS_EMIT && status.res_count == 2'd0)
      |=> (state_r == ies_pkg::CS_IDLE))
    else $error("empty step did not return to idle");
`endif

endmodule
`default_nettype wire

FILE: design/ies_dp.sv
// Datapath: configuration registers, transaction state, page offset unit
// (bit-serial remainder), result words and output register. Uses ies_pkg.
`default_nettype none
module ies_dp #(
  parameter int ADDR_BITS = ies_pkg::ADDR_BITS_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                cfg_we,
  input  wire [ies_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire [ies_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire [1:0]                          in_command,
  input  wire [15:0]                         in_mem_address,
  input  wire [7:0]                          in_data_byte,
  input  wire                                in_last_of_run,
  input  wire                                in_bus_nack,
  input  wire [7:0]                          in_bus_read_data,
  input  wire                                out_stall,
  output logic                               out_valid,
  output logic [2:0]                         out_bus_op,
  output logic [7:0]                         out_bus_byte,
  output logic                               out_host_done,
  output logic                               out_host_ok,
  output logic [7:0]                         out_host_read_data,
  output logic                               out_last,
  input  ies_pkg::ctl_cmd_t                  cmd,
  output ies_pkg::dp_status_t                status
);

  localparam int CW = $clog2(ADDR_BITS + 1);

  // Configuration registers
  logic [6:0] dev_r;
  logic [8:0] page_r;
  logic       wide_r;
  logic [7:0] retry_r;
  logic [7:0] wait_r;

  // Latched input item
  ies_pkg::cmd_t        cmd_in_r;
  logic [ADDR_BITS-1:0] addr_in_r;
  logic [7:0]           data_in_r;
  logic                 lastf_in_r;
  logic                 nack_in_r;
  logic [7:0]           rdata_in_r;

  // Transaction state
  ies_pkg::phase_t      phase_r, phase_nxt;
  logic [ADDR_BITS-1:0] cur_r, cur_nxt;
  logic [8:0]           room_r, room_nxt;
  logic [7:0]           probes_r, probes_nxt;
  logic [7:0]           held_r, held_nxt;
  logic [6:0]           ctrl_r, ctrl_nxt;
  ies_pkg::req_kind_t   rk_r, rk_nxt;
  logic                 run_r, run_nxt;

  // Page offset unit
  logic                 mod_busy_r;
  logic [CW-1:0]        mod_cnt_r;
  logic [ADDR_BITS-1:0] dvd_r;
  logic [8:0]           rem_r;
  logic [9:0]           rem_sh;

  // Result words of the step
  ies_pkg::result_t     res_a, res_b, res_a_r, res_b_r, res_sel;
  logic [1:0]           cnt_c, cnt_r;

  // Output register
  logic                 out_valid_r;
  ies_pkg::result_t     out_r;
  logic                 out_last_r;

  // Effective register values and derived addresses
  logic [8:0]           eff_page;
  logic [7:0]           eff_retry, eff_wait;
  logic [ADDR_BITS-1:0] new_addr;
  logic [15:0]          new_addr16;
  logic [6:0]           ctrl_new;
  logic [8:0]           room_dec;
  logic [7:0]           probes_dec;
  logic                 need_chunk;

  assign eff_page  = (page_r == 9'd0) ? ies_pkg::PAGE_RST :
                     (page_r > ies_pkg::PAGE_MAX) ? ies_pkg::PAGE_MAX : page_r;
  assign eff_retry = (retry_r == 8'd0) ? ies_pkg::RETRY_RST : retry_r;
  assign eff_wait  = (wait_r == 8'd0) ? ies_pkg::WAIT_RST : wait_r;

  // A write byte continues the open run or starts at its own address.
  assign new_addr   = run_r ? cur_r : addr_in_r;
  assign new_addr16 = 16'(new_addr);
  assign need_chunk = !run_r || (room_r == 9'd0);
  assign ctrl_new   = wide_r ? dev_r : (dev_r | {4'b0, new_addr16[10:8]});
  assign room_dec   = (room_r != 9'd0) ? room_r - 9'd1 : room_r;
  assign probes_dec = (probes_r != 8'd0) ? probes_r - 8'd1 : probes_r;

  assign status.need_mod  = (cmd_in_r == ies_pkg::CMD_WRITE) &&
                            (phase_r == ies_pkg::PH_IDLE) && need_chunk;
  assign status.mod_busy  = mod_busy_r;
  assign status.res_count = cnt_r;
  assign status.out_free  = !out_valid_r || !out_stall;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_r   <= ies_pkg::DEV_RST;
      page_r  <= ies_pkg::PAGE_RST;
      wide_r  <= 1'b0;
      retry_r <= ies_pkg::RETRY_RST;
      wait_r  <= ies_pkg::WAIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ies_pkg::REG_DEV:   dev_r   <= cfg_data[6:0];
        ies_pkg::REG_PAGE:  page_r  <= cfg_data[8:0];
        ies_pkg::REG_WIDE:  wide_r  <= cfg_data[0];
        ies_pkg::REG_RETRY: retry_r <= cfg_data[7:0];
        ies_pkg::REG_WAIT:  wait_r  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Input item capture
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      cmd_in_r   <= ies_pkg::cmd_t'(in_command);
      addr_in_r  <= in_mem_address[ADDR_BITS-1:0];
      data_in_r  <= in_data_byte;
      lastf_in_r <= in_last_of_run;
      nack_in_r  <= in_bus_nack;
      rdata_in_r <= in_bus_read_data;
    end
  end

  // Page offset: restoring remainder, one address bit per cycle
  assign rem_sh = {rem_r, dvd_r[ADDR_BITS-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_busy_r <= 1'b0;
      mod_cnt_r  <= '0;
    end else if (cmd.mod_start) begin
      mod_busy_r <= 1'b1;
      mod_cnt_r  <= CW'(ADDR_BITS);
    end else if (mod_busy_r) begin
      mod_cnt_r <= mod_cnt_r - CW'(1);
      if (mod_cnt_r == CW'(1)) mod_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mod_start) begin
      dvd_r <= new_addr;
      rem_r <= 9'd0;
    end else if (mod_busy_r) begin
      dvd_r <= dvd_r << 1;
      if (rem_sh >= {1'b0, eff_page}) rem_r <= 9'(rem_sh - {1'b0, eff_page});
      else rem_r <= rem_sh[8:0];
    end
  end

  // One step of the sequencer: next state and up to two result words
  always_comb begin
    phase_nxt  = phase_r;
    cur_nxt    = cur_r;
    room_nxt   = room_r;
    probes_nxt = probes_r;
    held_nxt   = held_r;
    ctrl_nxt   = ctrl_r;
    rk_nxt     = rk_r;
    run_nxt    = run_r;
    res_a      = '{op: ies_pkg::OP_NONE, bus_byte: 8'd0, done: 1'b0, ok: 1'b0, rdata: 8'd0};
    res_b      = res_a;
    cnt_c      = 2'd0;
    if (cmd_in_r == ies_pkg::CMD_RESP) begin
      if (nack_in_r && (phase_r == ies_pkg::PH_CTRL || phase_r == ies_pkg::PH_AHI ||
          phase_r == ies_pkg::PH_ALO || phase_r == ies_pkg::PH_DATA ||
          phase_r == ies_pkg::PH_RCTRL)) begin
        // Missing acknowledge: stop and report failure, closing any run.
        res_a.op   = ies_pkg::OP_STOP;
        res_b.done = 1'b1;
        cnt_c      = 2'd2;
        run_nxt    = 1'b0;
        room_nxt   = 9'd0;
        phase_nxt  = ies_pkg::PH_IDLE;
      end else begin
        case (phase_r)
          ies_pkg::PH_CTRL: begin
            res_a.op = ies_pkg::OP_WRITE;
            cnt_c    = 2'd1;
            if (wide_r) begin
              res_a.bus_byte = 8'(16'(cur_r) >> 8);
              phase_nxt      = ies_pkg::PH_AHI;
            end else begin
              res_a.bus_byte = 8'(cur_r);
              phase_nxt      = ies_pkg::PH_ALO;
            end
          end
          ies_pkg::PH_AHI: begin
            res_a.op       = ies_pkg::OP_WRITE;
            res_a.bus_byte = 8'(cur_r);
            cnt_c          = 2'd1;
            phase_nxt      = ies_pkg::PH_ALO;
          end
          ies_pkg::PH_ALO: begin
            if (rk_r == ies_pkg::RK_READ) begin
              res_a.op       = ies_pkg::OP_RESTART;
              res_b.op       = ies_pkg::OP_WRITE;
              res_b.bus_byte = {ctrl_r, 1'b1};
              cnt_c          = 2'd2;
              phase_nxt      = ies_pkg::PH_RCTRL;
            end else begin
              res_a.op       = ies_pkg::OP_WRITE;
              res_a.bus_byte = held_r;
              cnt_c          = 2'd1;
              phase_nxt      = ies_pkg::PH_DATA;
            end
          end
          ies_pkg::PH_DATA: begin
            cur_nxt  = cur_r + 1'b1;
            room_nxt = room_dec;
            if (rk_r == ies_pkg::RK_LASTBYTE || room_dec == 9'd0) begin
              // Chunk closed: stop, then poll for the write cycle to end.
              res_a.op       = ies_pkg::OP_STOP;
              res_b.op       = ies_pkg::OP_PROBE;
              res_b.bus_byte = {1'b0, ctrl_r};
              cnt_c          = 2'd2;
              probes_nxt     = eff_retry;
              phase_nxt      = ies_pkg::PH_PROBE;
            end else begin
              res_a.done = 1'b1;
              res_a.ok   = 1'b1;
              cnt_c      = 2'd1;
              phase_nxt  = ies_pkg::PH_IDLE;
            end
          end
          ies_pkg::PH_PROBE: begin
            if (!nack_in_r) begin
              if (rk_r == ies_pkg::RK_LASTBYTE) run_nxt = 1'b0;
              room_nxt   = 9'd0;
              phase_nxt  = ies_pkg::PH_IDLE;
              res_a.done = 1'b1;
              res_a.ok   = 1'b1;
              cnt_c      = 2'd1;
            end else begin
              probes_nxt     = probes_dec;
              res_a.op       = ies_pkg::OP_WAIT;
              res_a.bus_byte = eff_wait;
              cnt_c          = 2'd2;
              if (probes_dec == 8'd0) begin
                // Poll exhausted: fail without stop.
                run_nxt    = 1'b0;
                room_nxt   = 9'd0;
                phase_nxt  = ies_pkg::PH_IDLE;
                res_b.done = 1'b1;
              end else begin
                res_b.op       = ies_pkg::OP_PROBE;
                res_b.bus_byte = {1'b0, ctrl_r};
              end
            end
          end
          ies_pkg::PH_RCTRL: begin
            res_a.op  = ies_pkg::OP_READ;
            cnt_c     = 2'd1;
            phase_nxt = ies_pkg::PH_READ;
          end
          ies_pkg::PH_READ: begin
            res_a.op    = ies_pkg::OP_STOP;
            res_b.done  = 1'b1;
            res_b.ok    = 1'b1;
            res_b.rdata = rdata_in_r;
            cnt_c       = 2'd2;
            phase_nxt   = ies_pkg::PH_IDLE;
          end
          default: cnt_c = 2'd0;
        endcase
      end
    end else if (phase_r != ies_pkg::PH_IDLE) begin
      // Host request while an answer is awaited is dropped.
      cnt_c = 2'd0;
    end else if (cmd_in_r == ies_pkg::CMD_WRITE) begin
      run_nxt  = 1'b1;
      cur_nxt  = new_addr;
      held_nxt = data_in_r;
      rk_nxt   = lastf_in_r ? ies_pkg::RK_LASTBYTE : ies_pkg::RK_BYTE;
      if (need_chunk) begin
        // Open a new chunk bounded by the page end.
        ctrl_nxt       = ctrl_new;
        room_nxt       = eff_page - rem_r;
        res_a.op       = ies_pkg::OP_START;
        res_b.op       = ies_pkg::OP_WRITE;
        res_b.bus_byte = {ctrl_new, 1'b0};
        cnt_c          = 2'd2;
        phase_nxt      = ies_pkg::PH_CTRL;
      end else begin
        res_a.op       = ies_pkg::OP_WRITE;
        res_a.bus_byte = data_in_r;
        cnt_c          = 2'd1;
        phase_nxt      = ies_pkg::PH_DATA;
      end
    end else if (run_r) begin
      // Read or readiness request refused while a run is open.
      res_a.done = 1'b1;
      cnt_c      = 2'd1;
    end else if (cmd_in_r == ies_pkg::CMD_READ) begin
      cur_nxt        = addr_in_r;
      ctrl_nxt       = ctrl_new;
      rk_nxt         = ies_pkg::RK_READ;
      res_a.op       = ies_pkg::OP_START;
      res_b.op       = ies_pkg::OP_WRITE;
      res_b.bus_byte = {ctrl_new, 1'b0};
      cnt_c          = 2'd2;
      phase_nxt      = ies_pkg::PH_CTRL;
    end else begin
      ctrl_nxt       = dev_r;
      rk_nxt         = ies_pkg::RK_READY;
      probes_nxt     = eff_retry;
      res_a.op       = ies_pkg::OP_PROBE;
      res_a.bus_byte = {1'b0, dev_r};
      cnt_c          = 2'd1;
      phase_nxt      = ies_pkg::PH_PROBE;
    end
  end

  // Commit the step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= ies_pkg::PH_IDLE;
      cur_r    <= '0;
      room_r   <= 9'd0;
      probes_r <= 8'd0;
      held_r   <= 8'd0;
      ctrl_r   <= 7'd0;
      rk_r     <= ies_pkg::RK_BYTE;
      run_r    <= 1'b0;
      cnt_r    <= 2'd0;
    end else if (cmd.commit) begin
      phase_r  <= phase_nxt;
      cur_r    <= cur_nxt;
      room_r   <= room_nxt;
      probes_r <= probes_nxt;
      held_r   <= held_nxt;
      ctrl_r   <= ctrl_nxt;
      rk_r     <= rk_nxt;
      run_r    <= run_nxt;
      cnt_r    <= cnt_c;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_a_r <= res_a;
      res_b_r <= res_b;
    end
  end

  // Output register
  assign res_sel = cmd.emit_idx ? res_b_r : res_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_r      <= res_sel;
      out_last_r <= cmd.emit_last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_bus_op         = out_r.op;
  assign out_bus_byte       = out_r.bus_byte;
  assign out_host_done      = out_r.done;
  assign out_host_ok        = out_r.ok;
  assign out_host_read_data = out_r.rdata;
  assign out_last           = out_last_r;

`ifndef SYNTHESIS
  // The open chunk never holds more than one page.
  a_room_max: assert property (@(posedge clk) disable iff (!rst_n)
    room_r <= ies_pkg::PAGE_MAX)
    else $error("page room above a page");
  // Polling always has a probe left.
  a_probe_left: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == ies_pkg::PH_PROBE) |-> (probes_r != 8'd0))
    else $error("polling with no probes left");
  // With no run open there is no open chunk.
  a_run_room: assert property (@(posedge clk) disable iff (!rst_n)
    (!run_r) |-> (room_r == 9'd0))
    else $error("chunk open without a run");
  // A finished remainder lies below the page size.
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(mod_busy_r)) |-> (rem_r < eff_page))
    else $error("page offset out of range");
`endif

endmodule
`default_nettype wire

FILE: design/i2c_eeprom_transaction_sequencer.sv
// Top level of the serial EEPROM transaction sequencer.
// Instantiates ies_ctrl (sequencing) and ies_dp (state and results); uses ies_pkg.
//
//   Channel  Direction  Handshake            Contents
//   in_      input      in_valid / in_stall  host request or bus response
//   out_     output     out_valid/out_stall  one bus primitive or host report
//   cfg_     input      cfg_we               register index and data
//
// An item passes through the idle, evaluate, commit and emit states, emitting up
// to two result words; a write byte that opens a chunk also runs the bit-serial
// page offset between evaluate and commit.
// Reset is synchronous, active low, and clears all control state.
// A stalled output holds the last result word; the next step's words wait for it.
`default_nettype none
module i2c_eeprom_transaction_sequencer #(
  parameter int ADDR_BITS = ies_pkg::ADDR_BITS_DEF
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            cfg_we,
  input  wire [ies_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [ies_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire                            in_valid,
  output logic                           in_stall,
  input  wire [1:0]                      in_command,
  input  wire [15:0]                     in_mem_address,
  input  wire [7:0]                      in_data_byte,
  input  wire                            in_last_of_run,
  input  wire                            in_bus_nack,
  input  wire [7:0]                      in_bus_read_data,
  output logic                           out_valid,
  input  wire                            out_stall,
  output logic [2:0]                     out_bus_op,
  output logic [7:0]                     out_bus_byte,
  output logic                           out_host_done,
  output logic                           out_host_ok,
  output logic [7:0]                     out_host_read_data,
  output logic                           out_last
);

  ies_pkg::ctl_cmd_t   cmd;
  ies_pkg::dp_status_t status;

  // Sequencing controller
  ies_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath
  ies_dp #(
    .ADDR_BITS (ADDR_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_command         (in_command),
    .in_mem_address     (in_mem_address),
    .in_data_byte       (in_data_byte),
    .in_last_of_run     (in_last_of_run),
    .in_bus_nack        (in_bus_nack),
    .in_bus_read_data   (in_bus_read_data),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_bus_op         (out_bus_op),
    .out_bus_byte       (out_bus_byte),
    .out_host_done      (out_host_done),
    .out_host_ok        (out_host_ok),
    .out_host_read_data (out_host_read_data),
    .out_last           (out_last),
    .cmd                (cmd),
    .status             (status)
  );

endmodule
`default_nettype wire
